@@ src/rgb9e_pkg.sv @@
// Shared constants, types and helper functions for the rgb9e5 encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rgb9e_pkg;

   // Field widths
   localparam int FloatW  = 32;
   localparam int MagW    = 31;
   localparam int ExpFldW = 8;
   localparam int SigW    = 24;
   localparam int MantW   = 9;
   localparam int RndW    = 10;
   localparam int SexpW   = 5;
   localparam int ShiftW  = 8;

   // Positive magnitude of +Inf; anything above it is a NaN
   localparam logic [MagW-1:0] InfMag = 31'h7F80_0000;
   // 65408.0 = 511/512 * 2^16, largest value the format holds
   localparam logic [MagW-1:0] MaxMag = 31'h477F_8000;
   // Biased float exponent at which the shared exponent is zero (127 - 16)
   localparam logic [ExpFldW-1:0] ExpBase = 8'd111;
   // Shift offset: 127 - 1 (leading-one position) and mantissa scale
   localparam logic [ExpFldW:0] ShiftBase = 9'd126;
   // A shift at or above this always rounds to zero
   localparam logic [ShiftW-1:0] ShiftZero = 8'd25;
   localparam logic [SexpW:0] SexpMax = 6'd31;
   localparam logic [MantW-1:0] MantMax = 9'd511;

   typedef logic [MagW-1:0]  mag_type;
   typedef logic [SexpW:0]   sexp_type;

   // Clamp one binary32 pattern to [0, 65408]; sign dropped from the result
   function automatic mag_type clamp_mag(input logic [FloatW-1:0] x);
      mag_type m;
      m = x[MagW-1:0];
      if (x[FloatW-1] || (m > InfMag)) begin
         clamp_mag = '0;
      end else if (m > MaxMag) begin
         clamp_mag = MaxMag;
      end else begin
         clamp_mag = m;
      end
   endfunction

   // Effective exponent (denormals behave as exponent one)
   function automatic logic [ExpFldW-1:0] eff_exp(input mag_type m);
      eff_exp = (m[MagW-1:SigW-1] == '0) ? 8'd1 : m[MagW-1:SigW-1];
   endfunction

   // Significand with the hidden bit restored
   function automatic logic [SigW-1:0] full_sig(input mag_type m);
      full_sig = {(m[MagW-1:SigW-1] != '0), m[SigW-2:0]};
   endfunction

   // Right shift that turns a magnitude into a mantissa at shared exponent e
   function automatic logic [ShiftW-1:0] mant_shift(input mag_type m, input sexp_type e);
      logic [ExpFldW:0] t;
      t = ShiftBase + {3'b000, e} - {1'b0, eff_exp(m)};
      mant_shift = t[ShiftW-1:0];
   endfunction

   // Round half up: floor(s / 2^k + 0.5); k is never below 15 here
   function automatic logic [RndW-1:0] round_shift(input logic [SigW-1:0] s,
                                                   input logic [ShiftW-1:0] k);
      logic [SigW-1:0] q;
      logic [RndW:0]   r;
      q = s >> (k - 8'd1);
      r = {1'b0, q[RndW-1:0]} + 11'd1;
      if (k >= ShiftZero) begin
         round_shift = '0;
      end else begin
         round_shift = r[RndW:1];
      end
   endfunction

endpackage

`default_nettype wire

@@ src/rgb9e_clamp_max.sv @@
// Front two pipeline stages: clamp each channel, then pick the largest and
// derive the raw shared exponent. Depends on rgb9e_pkg.
`default_nettype none

module rgb9e_clamp_max (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [31:0]                  red_bits,
   input  wire logic [31:0]                  green_bits,
   input  wire logic [31:0]                  blue_bits,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output rgb9e_pkg::mag_type                out_red,
   output rgb9e_pkg::mag_type                out_green,
   output rgb9e_pkg::mag_type                out_blue,
   output rgb9e_pkg::mag_type                out_max,
   output rgb9e_pkg::sexp_type               out_exp
);

   logic v1_ff, v1_in, v2_ff, v2_in;
   logic adv1, adv2;
   rgb9e_pkg::mag_type r1_ff, g1_ff, b1_ff;
   rgb9e_pkg::mag_type r2_ff, g2_ff, b2_ff, m2_ff, max_in;
   rgb9e_pkg::sexp_type e2_ff, e_in;
   logic [rgb9e_pkg::ExpFldW-1:0] ef;

   // Stall chain: a stage moves when it is empty or its successor moves
   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;
   assign v1_in    = adv1 ? in_valid : v1_ff;
   assign v2_in    = adv2 ? v1_ff : v2_ff;

   // Largest clamped channel and its shared exponent, floored at zero
   always_comb begin
      max_in = r1_ff;
      if (g1_ff > max_in) begin
         max_in = g1_ff;
      end
      if (b1_ff > max_in) begin
         max_in = b1_ff;
      end
      ef = max_in[rgb9e_pkg::MagW-1:rgb9e_pkg::SigW-1];
      if (ef < rgb9e_pkg::ExpBase) begin
         e_in = '0;
      end else begin
         e_in = rgb9e_pkg::sexp_type'(ef - rgb9e_pkg::ExpBase);
      end
   end

   // Hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Stage one: clamp
   always_ff @(posedge clock) begin
      if (adv1) begin
         r1_ff <= rgb9e_pkg::clamp_mag(red_bits);
         g1_ff <= rgb9e_pkg::clamp_mag(green_bits);
         b1_ff <= rgb9e_pkg::clamp_mag(blue_bits);
      end
   end

   // Stage two: max and exponent
   always_ff @(posedge clock) begin
      if (adv2) begin
         r2_ff <= r1_ff;
         g2_ff <= g1_ff;
         b2_ff <= b1_ff;
         m2_ff <= max_in;
         e2_ff <= e_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_red   = r2_ff;
   assign out_green = g2_ff;
   assign out_blue  = b2_ff;
   assign out_max   = m2_ff;
   assign out_exp   = e2_ff;

   a_max_dominates: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (m2_ff >= r2_ff) && (m2_ff >= g2_ff) && (m2_ff >= b2_ff))
      else $error("max below a channel");

   a_clamp_limit: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (m2_ff <= rgb9e_pkg::MaxMag) && (e2_ff <= rgb9e_pkg::SexpMax))
      else $error("clamp or exponent out of range");

endmodule

`default_nettype wire

@@ src/rgb9e_round.sv @@
// Back two pipeline stages: round the largest channel and bump the shared
// exponent, then round all three mantissas and pack. Depends on rgb9e_pkg.
`default_nettype none

module rgb9e_round (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rgb9e_pkg::mag_type    in_red,
   input  wire rgb9e_pkg::mag_type    in_green,
   input  wire rgb9e_pkg::mag_type    in_blue,
   input  wire rgb9e_pkg::mag_type    in_max,
   input  wire rgb9e_pkg::sexp_type   in_exp,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [31:0]                out_word
);

   logic v3_ff, v3_in, v4_ff, v4_in;
   logic adv3, adv4, bump;
   logic [rgb9e_pkg::RndW-1:0] mm;
   rgb9e_pkg::mag_type r3_ff, g3_ff, b3_ff;
   rgb9e_pkg::sexp_type e3_ff, e3_in;
   logic [rgb9e_pkg::RndW-1:0] rr, gr, br;
   logic [rgb9e_pkg::MantW-1:0] rm, gm, bm;
   logic [31:0] word_ff, word_in;

   // Stall chain
   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign in_ready = adv3;
   assign v3_in    = adv3 ? in_valid : v3_ff;
   assign v4_in    = adv4 ? v3_ff : v4_ff;

   // Round the max; a carry to 512 doubles the scale
   always_comb begin
      mm    = rgb9e_pkg::round_shift(rgb9e_pkg::full_sig(in_max),
                                     rgb9e_pkg::mant_shift(in_max, in_exp));
      bump  = mm[rgb9e_pkg::MantW];
      e3_in = in_exp + {5'd0, bump};
      if (e3_in > rgb9e_pkg::SexpMax) begin
         e3_in = rgb9e_pkg::SexpMax;
      end
   end

   // Round each channel at the final scale, saturate and pack
   always_comb begin
      rr = rgb9e_pkg::round_shift(rgb9e_pkg::full_sig(r3_ff),
                                  rgb9e_pkg::mant_shift(r3_ff, e3_ff));
      gr = rgb9e_pkg::round_shift(rgb9e_pkg::full_sig(g3_ff),
                                  rgb9e_pkg::mant_shift(g3_ff, e3_ff));
      br = rgb9e_pkg::round_shift(rgb9e_pkg::full_sig(b3_ff),
                                  rgb9e_pkg::mant_shift(b3_ff, e3_ff));
      rm = rr[rgb9e_pkg::MantW] ? rgb9e_pkg::MantMax : rr[rgb9e_pkg::MantW-1:0];
      gm = gr[rgb9e_pkg::MantW] ? rgb9e_pkg::MantMax : gr[rgb9e_pkg::MantW-1:0];
      bm = br[rgb9e_pkg::MantW] ? rgb9e_pkg::MantMax : br[rgb9e_pkg::MantW-1:0];
      word_in = {e3_ff[rgb9e_pkg::SexpW-1:0], bm, gm, rm};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Stage three: final exponent
   always_ff @(posedge clock) begin
      if (adv3) begin
         r3_ff <= in_red;
         g3_ff <= in_green;
         b3_ff <= in_blue;
         e3_ff <= e3_in;
      end
   end

   // Stage four: output word
   always_ff @(posedge clock) begin
      if (adv4) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_word  = word_ff;

   a_bump_nonzero: assert property (@(posedge clock) disable iff (reset)
      (in_valid && adv3 && bump) |=> (e3_ff != '0))
      else $error("exponent bump lost");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && adv4) |=> v4_ff)
      else $error("beat dropped between rounding stages");

endmodule

`default_nettype wire

@@ src/rgb9e5_encoder_core.sv @@
// Top level of the rgb9e5 shared-exponent encoder.
// Instantiates rgb9e_clamp_max and rgb9e_round; depends on rgb9e_pkg.
//
// Usage:
//  - req channel: one beat per pixel, tdata carries three binary32 channel
//    patterns (red low, then green, then blue).
//  - rsp channel: one beat per pixel, tdata carries the packed word with the
//    5-bit shared exponent in bits 31..27 and blue, green, red mantissas below.
//  - Throughput: one pixel per cycle while rsp_tready is high; four register
//    stages (clamp, max and exponent, max rounding and bump, channel rounding
//    and pack) each hold one beat.
//  - Negative and NaN channels encode as zero, values above 65408 saturate.
//  - Reset (synchronous, active high) empties all stages; no beat is
//    presented on rsp until new data arrives.
//  - When rsp_tready is low, the output beat holds and the stages behind it
//    keep filling; req_tready falls only once every stage is occupied.
`default_nettype none

module rgb9e5_encoder_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // red_bits, green_bits, blue_bits
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata    // packed_word
);

   logic mid_valid, mid_ready;
   rgb9e_pkg::mag_type mid_red, mid_green, mid_blue, mid_max;
   rgb9e_pkg::sexp_type mid_exp;

   rgb9e_clamp_max u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .red_bits   (req_tdata[31:0]),
      .green_bits (req_tdata[63:32]),
      .blue_bits  (req_tdata[95:64]),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_red    (mid_red),
      .out_green  (mid_green),
      .out_blue   (mid_blue),
      .out_max    (mid_max),
      .out_exp    (mid_exp)
   );

   rgb9e_round u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_red    (mid_red),
      .in_green  (mid_green),
      .in_blue   (mid_blue),
      .in_max    (mid_max),
      .in_exp    (mid_exp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ tb/rgb9e5_encoder_core_test.sv @@
// Testbench for rgb9e5_encoder_core: drives pixel beats, predicts each packed word.
// Self-contained; needs only the encoder RTL (ports are plain vectors).
`timescale 1ns / 1ps

module rgb9e5_encoder_core_test;

   localparam int  RandomPixels = 1950;
   localparam int  CycleLimit   = 400000;
   localparam int  HoldCycles   = 300;

   typedef struct {
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
      bit          wait_drain;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // red_bits, green_bits, blue_bits
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // packed_word

   pixel_type   pixel_queue[$];
   logic [31:0] packed_expect[$];
   int          sent_count  = 0;
   int          recv_count  = 0;
   int          hold_left   = 0;
   bit          hold_done   = 0;
   bit          failed      = 0;
   int          cycle_count = 0;

   rgb9e5_encoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Exact power of two as a double
   function automatic real pow2(input int e);
      real d;
      d = 1.0;
      if (e > 64) e = 64;
      if (e < -64) e = -64;
      for (int i = 0; i < e; i++) d = d * 2.0;
      for (int i = 0; i > e; i--) d = d * 0.5;
      return d;
   endfunction

   // Clamp a binary32 pattern to [0, 65408]; returns the magnitude pattern
   function automatic logic [30:0] clamp_channel(input logic [31:0] x);
      if (x[31] || x[30:0] > 31'h7F80_0000) return '0;
      if (x[30:0] > 31'h477F_8000) return 31'h477F_8000;
      return x[30:0];
   endfunction

   // Value of a non-negative finite binary32 magnitude
   function automatic real mag_value(input logic [30:0] m);
      int ef;
      real sig;
      ef  = int'(m[30:23]);
      sig = real'({ef != 0, m[22:0]});
      return sig * pow2(((ef == 0) ? 1 : ef) - 150);
   endfunction

   // Round half up at the given scale, saturating at 1023
   function automatic int round_mant(input logic [30:0] m, input real scale);
      real v;
      v = mag_value(m) / scale + 0.5;
      if (!(v > 0.0)) return 0;
      if (v >= 1024.0) return 1023;
      return $rtoi(v);
   endfunction

   // Predict the packed shared-exponent word for one pixel
   function automatic logic [31:0] encode_pixel(input pixel_type p);
      logic [30:0] rc, gc, bc, mx;
      int e, rm, gm, bm;
      real scale;
      rc = clamp_channel(p.red);
      gc = clamp_channel(p.green);
      bc = clamp_channel(p.blue);
      mx = rc;
      if (gc > mx) mx = gc;
      if (bc > mx) mx = bc;
      e = int'(mx[30:23]) - 111;
      if (e < 0) e = 0;
      scale = pow2(e - 24);
      if (round_mant(mx, scale) >= 512) begin
         scale = scale * 2.0;
         e = e + 1;
      end
      if (e > 31) e = 31;
      rm = round_mant(rc, scale);
      gm = round_mant(gc, scale);
      bm = round_mant(bc, scale);
      if (rm > 511) rm = 511;
      if (gm > 511) gm = 511;
      if (bm > 511) bm = 511;
      return {e[4:0], bm[8:0], gm[8:0], rm[8:0]};
   endfunction

   function automatic logic [31:0] random_channel();
      logic [31:0] x;
      x = $urandom;
      case ($urandom_range(0, 3))
         0: ;
         1: x[30:23] = 8'($urandom_range(95, 145));
         default: begin
            x[31] = ($urandom_range(0, 9) == 0);
            x[30:23] = 8'($urandom_range(105, 142));
         end
      endcase
      return x;
   endfunction

   task automatic add_pixel(input logic [31:0] r, g, b, input bit drain);
      pixel_type p;
      p.red = r;
      p.green = g;
      p.blue = b;
      p.wait_drain = drain;
      pixel_queue.push_back(p);
   endtask

   // Sender: feed req beats from the pending queue
   always @(posedge clock) begin
      pixel_type p;
      bit        give;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            p = pixel_queue.pop_front();
            packed_expect.push_back(encode_pixel(p));
            sent_count++;
         end
         if (!(req_tvalid && !req_tready)) begin
            give = pixel_queue.size() > 0;
            if (give && pixel_queue[0].wait_drain && packed_expect.size() > 0)
               give = 1'b0;
            if (give && sent_count < 650 && $urandom_range(0, 99) < 7) give = 1'b0;
            if (give && sent_count >= 650 && sent_count < 1300 &&
                $urandom_range(0, 99) < 74) give = 1'b0;
            if (give) begin
               p = pixel_queue[0];
               req_tdata <= {p.blue, p.green, p.red};
            end
            req_tvalid <= give;
         end
      end
   end

   // Receiver: check rsp beats against the oldest expectation
   always @(posedge clock) begin
      logic [31:0] want;
      int          stall;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            recv_count++;
            if (packed_expect.size() == 0) begin
               $error("unexpected beat packed_word actual %h", rsp_tdata);
               failed = 1;
            end else begin
               want = packed_expect.pop_front();
               if (rsp_tdata !== want) begin
                  $error("packed_word expected %h actual %h", want, rsp_tdata);
                  failed = 1;
               end
            end
         end
         if (!hold_done && recv_count == 300) begin
            hold_done = 1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall = (sent_count < 650) ? 74 : (sent_count < 1300) ? 7 : 0;
            rsp_tready <= ($urandom_range(0, 99) >= stall);
         end
      end
   end

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      // Directed corners: zeros, signs, NaN, infinities, clamp edge, denormals
      add_pixel(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 0);
      add_pixel(32'hBF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 0);
      add_pixel(32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001, 0);
      add_pixel(32'h7F7F_FFFF, 32'h477F_8000, 32'h477F_8001, 0);
      add_pixel(32'h477F_8000, 32'h0000_0000, 32'h3F80_0000, 0);
      add_pixel(32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 0);
      add_pixel(32'h3F80_0000, 32'h3F00_0000, 32'h3E80_0000, 0);
      add_pixel(32'h3FFF_FFFF, 32'h3F80_0000, 32'h0000_0000, 0);
      add_pixel(32'h43FF_C000, 32'h43FF_8000, 32'h43FF_BFFF, 0);
      add_pixel(32'h3780_0000, 32'h3700_0000, 32'h3800_0000, 0);
      add_pixel(32'h3380_0000, 32'h3300_0000, 32'h3400_0000, 0);
      add_pixel(32'h477F_FFFF, 32'h4780_0000, 32'h4700_0000, 0);
      add_pixel(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 0);
      add_pixel(32'h3F80_2000, 32'h3A80_0000, 32'h3B00_0001, 0);
      add_pixel(32'h7FFF_FFFF, 32'h0000_0000, 32'h3FFF_FFFF, 0);
      for (int i = 0; i < RandomPixels; i++) begin
         add_pixel(random_channel(), random_channel(), random_channel(),
                   i == 500 || i == 1500);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pixel_queue.size() > 0 || packed_expect.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed && packed_expect.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
